@@ hw/rtl/host_address_text_parser_defines.svh @@
// Assertion macros shared by the host address text parser RTL.
// Self-contained; taken in by `include where assertions are written.
`ifndef HOST_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define HOST_ADDRESS_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("host address text parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("host address text parser: next-cycle check failed");

`endif

@@ hw/rtl/hap_pkg.sv @@
// Shared types and constants of the host address text parser.
// No dependencies; imported by hap_parse_core and host_address_text_parser.
package hap_pkg;

    localparam int ADDRESS_BYTES = 4;
    localparam int ADDR_W        = ADDRESS_BYTES * 8;
    localparam int FI_W          = $clog2(ADDRESS_BYTES);
    localparam int POS_W         = $clog2(2 * ADDRESS_BYTES + 3);
    localparam int OUT_ADDR_W    = 32;

    // Register map: byte addresses on the configuration port.
    localparam int         PADDR_W    = 4;
    localparam logic [3:0] ADDR_NET    = 4'h0;
    localparam logic [3:0] ADDR_SUBNET = 4'h4;
    localparam logic [3:0] ADDR_THIRD  = 4'h8;

    localparam logic [7:0] RESET_NET    = 8'o22;
    localparam logic [7:0] RESET_SUBNET = 8'o11;
    localparam logic [7:0] RESET_THIRD  = 8'o0;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [8:0] FIELD_MAX = 9'o377;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_LOOKUP    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] net;
        logic [7:0] subnet;
        logic [7:0] third;
    } t_defaults;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        t_status               status;
    } t_result;

endpackage

@@ hw/rtl/hap_parse_core.sv @@
// Per-character parse state of the host address text parser.
// Depends on hap_pkg; instantiated by host_address_text_parser.
module hap_parse_core
    import hap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  t_defaults  i_defaults,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        FORM_UNDECIDED = 2'd0,
        FORM_NUMERIC   = 2'd1,
        FORM_HEX       = 2'd2,
        FORM_SYMBOLIC  = 2'd3
    } t_form;

    localparam int EXT_W = (ADDR_W > OUT_ADDR_W) ? ADDR_W : OUT_ADDR_W;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    t_form              r_form, n_form, w_form;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_early, n_early;
    logic [FI_W-1:0]    r_fi, n_fi;
    logic [7:0]         r_dacc, n_dacc, r_oacc, n_oacc;
    logic [ADDR_W-1:0]  r_dsr, n_dsr, r_osr, n_osr;
    logic               r_derr, n_derr, r_oerr, n_oerr;
    logic [ADDR_W-1:0]  r_hacc, n_hacc;
    logic               r_herr, n_herr;

    logic               w_digit;
    logic [3:0]         w_dval;
    logic [11:0]        w_dsum;
    logic [10:0]        w_osum;
    logic [4:0]         w_hex;
    logic [ADDR_W-1:0]  w_daddr, w_oaddr;
    logic [EXT_W-1:0]   w_ext;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            v = {1'b1, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    function automatic logic [7:0] default_byte(input int k, input t_defaults d);
        logic [7:0] b;
        b = 8'h00;
        if (k == 0) begin
            b = d.net;
        end else if (k == 1) begin
            b = d.subnet;
        end else if (k == 2) begin
            b = d.third;
        end
        return b;
    endfunction

    // Fields sit right-aligned; the shift line holds earlier fields, the
    // accumulator the last one, and leading bytes fall back to defaults.
    function automatic logic [ADDR_W-1:0] assemble(
        input logic [ADDR_W-1:0] sr,
        input logic [7:0]        acc,
        input logic [FI_W-1:0]   fi,
        input t_defaults         d
    );
        logic [ADDR_W-1:0] full;
        logic [ADDR_W-1:0] v;
        full = {sr[ADDR_W-9:0], acc};
        v    = '0;
        for (int j = 0; j < ADDRESS_BYTES; j++) begin
            if (FI_W'(j) <= fi) begin
                v[j*8 +: 8] = full[j*8 +: 8];
            end else begin
                v[j*8 +: 8] = default_byte(ADDRESS_BYTES - 1 - j, d);
            end
        end
        return v;
    endfunction

    assign w_digit = (i_char inside {[8'h30:8'h39]});
    assign w_dval  = 4'(i_char - CH_ZERO);
    assign w_dsum  = {4'b0, r_dacc} * 12'd10 + {8'b0, w_dval};
    assign w_osum  = {r_oacc, 3'b000} + {7'b0, w_dval};
    assign w_hex   = hex_value(i_char);
    assign w_daddr = assemble(r_dsr, r_dacc, r_fi, i_defaults);
    assign w_oaddr = assemble(r_osr, r_oacc, r_fi, i_defaults);

    // Result seen at a terminating NUL.
    always_comb begin
        logic [ADDR_W-1:0] addr;
        t_status           st;
        addr = '0;
        st   = ST_MALFORMED;
        case (r_form)
            FORM_UNDECIDED, FORM_SYMBOLIC: begin
                st = ST_LOOKUP;
            end
            FORM_HEX: begin
                if (!r_herr && r_pos == POS_W'(2 * ADDRESS_BYTES + 1)) begin
                    addr = r_hacc;
                    st   = ST_OK;
                end
            end
            FORM_NUMERIC: begin
                if (r_early && !r_derr) begin
                    addr = w_daddr;
                    st   = ST_OK;
                end else if (!r_early && !r_oerr) begin
                    addr = w_oaddr;
                    st   = ST_OK;
                end
            end
            default: begin
                st = ST_MALFORMED;
            end
        endcase
        w_ext           = EXT_W'(addr);
        o_result.addr   = w_ext[OUT_ADDR_W-1:0];
        o_result.status = st;
    end

    always_comb begin
        n_form  = r_form;
        n_pos   = r_pos;
        n_early = r_early;
        n_fi    = r_fi;
        n_dacc  = r_dacc;
        n_oacc  = r_oacc;
        n_dsr   = r_dsr;
        n_osr   = r_osr;
        n_derr  = r_derr;
        n_oerr  = r_oerr;
        n_hacc  = r_hacc;
        n_herr  = r_herr;
        w_form  = r_form;

        if (r_form == FORM_UNDECIDED) begin
            if (w_digit) begin
                w_form = FORM_NUMERIC;
            end else if (i_char == CH_HASH) begin
                w_form = FORM_HEX;
            end else begin
                w_form = FORM_SYMBOLIC;
            end
        end

        if (i_accept) begin
            if (i_char == CH_NUL) begin
                n_form  = FORM_UNDECIDED;
                n_pos   = '0;
                n_early = 1'b0;
                n_fi    = '0;
                n_dacc  = '0;
                n_oacc  = '0;
                n_derr  = 1'b0;
                n_oerr  = 1'b0;
                n_herr  = 1'b0;
            end else begin
                n_form = w_form;
                if (w_form == FORM_NUMERIC) begin
                    if (w_digit) begin
                        if (!r_derr) begin
                            if (w_dsum > 12'(FIELD_MAX)) begin
                                n_derr = 1'b1;
                                n_dacc = '0;
                            end else begin
                                n_dacc = w_dsum[7:0];
                            end
                        end
                        if (!r_oerr) begin
                            if (w_dval > 4'd7) begin
                                n_oerr = 1'b1;
                            end else if (w_osum > 11'(FIELD_MAX)) begin
                                n_oerr = 1'b1;
                                n_oacc = '0;
                            end else begin
                                n_oacc = w_osum[7:0];
                            end
                        end
                    end else if (i_char == CH_DOT || i_char == CH_COMMA) begin
                        if (i_char == CH_DOT) begin
                            n_oerr = 1'b1;
                            if (r_pos inside {[1:3]}) begin
                                n_early = 1'b1;
                            end
                        end else begin
                            n_derr = 1'b1;
                        end
                        if (r_fi == FI_W'(ADDRESS_BYTES - 1)) begin
                            n_derr = 1'b1;
                            n_oerr = 1'b1;
                        end else begin
                            // A field pushed while its form is in error is never read.
                            n_dsr  = {r_dsr[ADDR_W-9:0], r_dacc};
                            n_osr  = {r_osr[ADDR_W-9:0], r_oacc};
                            n_fi   = r_fi + 1'b1;
                            n_dacc = '0;
                            n_oacc = '0;
                        end
                    end else begin
                        n_derr = 1'b1;
                        n_oerr = 1'b1;
                    end
                end else if (w_form == FORM_HEX && r_pos != '0) begin
                    if (!w_hex[4] || r_pos > POS_W'(2 * ADDRESS_BYTES)) begin
                        n_herr = 1'b1;
                    end else begin
                        n_hacc = {r_hacc[ADDR_W-5:0], w_hex[3:0]};
                    end
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form  <= FORM_UNDECIDED;
            r_pos   <= '0;
            r_early <= 1'b0;
            r_fi    <= '0;
            r_dacc  <= '0;
            r_oacc  <= '0;
            r_derr  <= 1'b0;
            r_oerr  <= 1'b0;
            r_herr  <= 1'b0;
        end else begin
            r_form  <= n_form;
            r_pos   <= n_pos;
            r_early <= n_early;
            r_fi    <= n_fi;
            r_dacc  <= n_dacc;
            r_oacc  <= n_oacc;
            r_derr  <= n_derr;
            r_oerr  <= n_oerr;
            r_herr  <= n_herr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsr  <= n_dsr;
        r_osr  <= n_osr;
        r_hacc <= n_hacc;
    end

endmodule

@@ hw/rtl/host_address_text_parser.sv @@
// Host address text parser: top level with configuration registers and result register.
// Depends on hap_pkg, hap_parse_core and host_address_text_parser_defines.svh.
//
// Usage. Characters of a host string arrive one per beat on the slave stream
// (s_axis, 8-bit tdata). A NUL character ends the string; only that beat
// produces a result, one beat on the master stream carrying the 32-bit
// address and a 2-bit status (ok, malformed, name lookup needed). Accepted
// forms are '#' with eight hex digits, dotted decimal and comma-joined octal,
// with missing leading bytes taken from three byte registers on the APB port.
// Throughput is one character per cycle: the parse state is updated by short
// logic in the cycle a character is accepted. The output register captures
// the result on the clock edge at which the NUL beat is accepted.
// When the receiver stalls, the result is held and the input keeps taking
// characters only while the output register is empty or being drained; a
// held result blocks new characters. Reset (synchronous, active low) clears
// the parse state and returns the default bytes to 18, 9 and 0. Registers
// are to be written only while no string is in progress.
`include "host_address_text_parser_defines.svh"

module host_address_text_parser
    import hap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave stream: tdata[7:0] = char_code.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    // Master stream: tdata[31:0] = host_address, [33:32] = parse_status,
    // [39:34] = zero padding.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata,
    // APB configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_defaults r_defaults;
    t_result   w_result;
    t_result   r_result;
    logic      r_out_valid;
    logic      w_in_accept;
    logic      w_out_accept;
    logic      w_cfg_write;

    // A new character may enter whenever the result register is free or
    // is being taken in this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_accept  = m_axis_tvalid && m_axis_tready;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults.net    <= RESET_NET;
            r_defaults.subnet <= RESET_SUBNET;
            r_defaults.third  <= RESET_THIRD;
        end else if (w_cfg_write) begin
            if (paddr == ADDR_NET) begin
                r_defaults.net <= pwdata[7:0];
            end
            if (paddr == ADDR_SUBNET) begin
                r_defaults.subnet <= pwdata[7:0];
            end
            if (paddr == ADDR_THIRD) begin
                r_defaults.third <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_NET) begin
            prdata = {24'b0, r_defaults.net};
        end else if (paddr == ADDR_SUBNET) begin
            prdata = {24'b0, r_defaults.subnet};
        end else if (paddr == ADDR_THIRD) begin
            prdata = {24'b0, r_defaults.third};
        end
    end

    hap_parse_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_accept),
        .i_char     (s_axis_tdata),
        .i_defaults (r_defaults),
        .o_result   (w_result)
    );

    // The result register loads only on a NUL beat; its valid flag drops
    // once the beat has been taken and no new result replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && s_axis_tdata == CH_NUL) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && s_axis_tdata == CH_NUL) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_result.status, r_result.addr};

    // A failed parse must never leak a partial address.
    `HAP_ASSERT_NOW(a_addr_zero_unless_ok, i_clk, i_rst_n, m_axis_tvalid && r_result.status != ST_OK, r_result.addr == '0)
    // A NUL beat always leaves a result waiting.
    `HAP_ASSERT_NEXT(a_nul_gives_result, i_clk, i_rst_n, w_in_accept && s_axis_tdata == CH_NUL, m_axis_tvalid)
    // Ordinary characters never create a result out of nothing.
    `HAP_ASSERT_NEXT(a_char_no_result, i_clk, i_rst_n, w_in_accept && s_axis_tdata != CH_NUL && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid)

endmodule
